>>> src/fpba_pkg.sv
// Shared constants, codes and control structs for the fit-policy block allocator.
// Depends on nothing; every other file of the block imports this package.
`default_nettype none

package fpba_pkg;

  // Table geometry.
  localparam int NUM_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

  // Fixed field widths of the words on the channels and the config port.
  localparam int BLK_FIELD_W  = 4;
  localparam int SIZE_FIELD_W = 16;
  localparam int MODE_W       = 2;
  localparam int BIU_W        = 5;
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;

  // Item commands.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // Fit policies. The unused code behaves as first fit.
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  // Register indexes (byte address bit 2).
  localparam logic REG_FIT_MODE      = 1'b0;
  localparam logic REG_BLOCKS_IN_USE = 1'b1;

  // Reset values of the registers.
  localparam logic [MODE_W-1:0] FIT_MODE_RST      = MODE_FIRST;
  localparam logic [BIU_W-1:0]  BLOCKS_IN_USE_RST = 5'd16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // latch the accepted word and restart the scan
    logic step;    // examine one block
    logic finish;  // update the table and load the result register
  } fpba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_load;
    logic scan_done;
  } fpba_stat_t;

endpackage

`default_nettype wire

>>> src/fpba_if.sv
// Valid/ready channel interfaces for the allocator's input and result words.
// Depends on fpba_pkg for the field widths.
`default_nettype none

interface fpba_in_if;
  import fpba_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [BLK_FIELD_W-1:0]  block_index;
  logic [SIZE_FIELD_W-1:0] size_value;

  modport source (output valid, cmd, block_index, size_value, input ready);
  modport sink   (input valid, cmd, block_index, size_value, output ready);
endinterface

interface fpba_out_if;
  import fpba_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    granted;
  logic [BLK_FIELD_W-1:0]  chosen_block;
  logic [SIZE_FIELD_W-1:0] capacity_left;

  modport source (output valid, granted, chosen_block, capacity_left, input ready);
  modport sink   (input valid, granted, chosen_block, capacity_left, output ready);
endinterface

`default_nettype wire

>>> src/fpba_regs.sv
// APB-style configuration registers: fit policy and number of scanned blocks.
// Depends on fpba_pkg for widths, register indexes and reset values.
`default_nettype none

module fpba_regs
  import fpba_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [MODE_W-1:0]     fit_mode,
  output logic      [BIU_W-1:0]      blocks_in_use
);

  logic              wr_en;
  logic [MODE_W-1:0] fit_mode_r;
  logic [BIU_W-1:0]  blocks_in_use_r;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r      <= FIT_MODE_RST;
      blocks_in_use_r <= BLOCKS_IN_USE_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_FIT_MODE:      fit_mode_r      <= pwdata[MODE_W-1:0];
        REG_BLOCKS_IN_USE: blocks_in_use_r <= pwdata[BIU_W-1:0];
        default:           ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (paddr[2])
      REG_FIT_MODE:      prdata = {{(APB_DATA_W-MODE_W){1'b0}}, fit_mode_r};
      REG_BLOCKS_IN_USE: prdata = {{(APB_DATA_W-BIU_W){1'b0}}, blocks_in_use_r};
      default:           prdata = '0;
    endcase
  end

  assign fit_mode      = fit_mode_r;
  assign blocks_in_use = blocks_in_use_r;

endmodule

`default_nettype wire

>>> src/fpba_ctrl.sv
// Controller: sequences accept, block-by-block scan and result hand-off.
// Depends on fpba_pkg for the command and status structs.
`default_nettype none

module fpba_ctrl
  import fpba_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire fpba_stat_t stat,
  output fpba_cmd_t       cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;
  logic work_done;

  // The result register may be reloaded when empty or being drained.
  assign slot_free = !out_valid_r || out_ready;
  assign work_done = stat.is_load || stat.scan_done;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (!work_done) begin
          cmd.step = 1'b1;
        end else if (slot_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result valid flag of the output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A result never overwrites one that has not been taken.
  a_finish_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  // Every accepted word is followed by busy work.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (state_r == ST_BUSY))
    else $error("accepted word without busy state");

  // Finishing always presents a result in the next cycle.
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finish did not produce a result");

endmodule

`default_nettype wire

>>> src/fpba_dp.sv
// Datapath: capacity table, scan counter, fit comparison and result register.
// Depends on fpba_pkg for widths, codes and the command and status structs.
`default_nettype none

module fpba_dp
  import fpba_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire fpba_cmd_t               cmd,
  output fpba_stat_t                   stat,
  input  wire logic [MODE_W-1:0]       fit_mode,
  input  wire logic [BIU_W-1:0]        blocks_in_use,
  input  wire logic                    in_cmd,
  input  wire logic [BLK_FIELD_W-1:0]  in_block_index,
  input  wire logic [SIZE_FIELD_W-1:0] in_size_value,
  output logic                         out_granted,
  output logic      [BLK_FIELD_W-1:0]  out_chosen_block,
  output logic      [SIZE_FIELD_W-1:0] out_capacity_left
);

  logic [SIZE_BITS-1:0] mem_r [NUM_BLOCKS];

  logic                 cmd_r;
  logic [IDX_W-1:0]     idx_r;
  logic [SIZE_BITS-1:0] size_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 found_r;
  logic [IDX_W-1:0]     pick_r;
  logic [SIZE_BITS-1:0] best_r;

  logic                 granted_r;
  logic [IDX_W-1:0]     chosen_r;
  logic [SIZE_BITS-1:0] cap_left_r;

  logic [CNT_W-1:0]     limit;
  logic [SIZE_BITS-1:0] cap;
  logic                 fits;
  logic                 take;
  logic [SIZE_BITS-1:0] cap_after;

  // Scan bound: counts beyond the table size scan the whole table.
  assign limit = ({{(CNT_W > BIU_W ? CNT_W - BIU_W : 0){1'b0}}, blocks_in_use}
                  > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                        : CNT_W'(blocks_in_use);

  assign stat.is_load   = (cmd_r == CMD_LOAD);
  assign stat.scan_done = (cnt_r >= limit);

  // One table read per cycle at the scan position.
  assign cap  = mem_r[cnt_r[IDX_W-1:0]];
  assign fits = (cap >= size_r);

  // Fit policy: first fit keeps the first candidate, best and worst replace
  // only on a strictly better capacity so ties stay at the lowest index.
  always_comb begin
    take = 1'b0;
    if (fits) begin
      if (!found_r) begin
        take = 1'b1;
      end else begin
        case (fit_mode)
          MODE_BEST:  take = (cap < best_r);
          MODE_WORST: take = (cap > best_r);
          default:    take = 1'b0;
        endcase
      end
    end
  end

  assign cap_after = best_r - size_r;

  // Item latch and scan state.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cmd_r   <= in_cmd;
      idx_r   <= in_block_index[IDX_W-1:0];
      size_r  <= in_size_value[SIZE_BITS-1:0];
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.step) begin
      cnt_r <= cnt_r + 1'b1;
      if (take) begin
        found_r <= 1'b1;
        pick_r  <= cnt_r[IDX_W-1:0];
        best_r  <= cap;
      end
    end
  end

  // Capacity table, cleared at reset and written at most once per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        mem_r[i] <= '0;
      end
    end else if (cmd.finish) begin
      if (cmd_r == CMD_LOAD) begin
        mem_r[idx_r] <= size_r;
      end else if (found_r) begin
        mem_r[pick_r] <= cap_after;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (cmd_r == CMD_LOAD) begin
        granted_r  <= 1'b1;
        chosen_r   <= idx_r;
        cap_left_r <= size_r;
      end else if (found_r) begin
        granted_r  <= 1'b1;
        chosen_r   <= pick_r;
        cap_left_r <= cap_after;
      end else begin
        granted_r  <= 1'b0;
        chosen_r   <= '0;
        cap_left_r <= '0;
      end
    end
  end

  assign out_granted       = granted_r;
  assign out_chosen_block  = BLK_FIELD_W'(chosen_r);
  assign out_capacity_left = SIZE_FIELD_W'(cap_left_r);

endmodule

`default_nettype wire

>>> src/fit_policy_block_allocator_top.sv
// Fit-policy block allocator: keeps the remaining capacity of 16 blocks (all
// zero after reset) and serves load and allocate words under first, best or
// worst fit. A load word is finished without a scan; an allocate word scans
// min(blocks_in_use, 16) table entries, reading one entry per cycle through
// a single comparator, before its result is registered. The block takes one
// word at a time, but accepts the next word while the previous result still
// waits in the output register. Configuration is to be written over the APB
// port only while the block is idle; the block itself does not enforce this.
// Depends on fpba_pkg, fpba_if, fpba_regs, fpba_ctrl and fpba_dp.
`default_nettype none

module fit_policy_block_allocator_top
  import fpba_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  fpba_in_if.sink                    in_ch,
  fpba_out_if.source                 out_ch,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [APB_ADDR_W-1:0] cfg_paddr,
  input  wire logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic      [APB_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  logic [MODE_W-1:0] fit_mode;
  logic [BIU_W-1:0]  blocks_in_use;
  fpba_cmd_t         cmd;
  fpba_stat_t        stat;
  logic              in_ready;
  logic              out_valid;

  fpba_regs u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (cfg_psel),
    .penable       (cfg_penable),
    .pwrite        (cfg_pwrite),
    .paddr         (cfg_paddr),
    .pwdata        (cfg_pwdata),
    .prdata        (cfg_prdata),
    .pready        (cfg_pready),
    .fit_mode      (fit_mode),
    .blocks_in_use (blocks_in_use)
  );

  fpba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fpba_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .fit_mode          (fit_mode),
    .blocks_in_use     (blocks_in_use),
    .in_cmd            (in_ch.cmd),
    .in_block_index    (in_ch.block_index),
    .in_size_value     (in_ch.size_value),
    .out_granted       (out_ch.granted),
    .out_chosen_block  (out_ch.chosen_block),
    .out_capacity_left (out_ch.capacity_left)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire
